/* rtl/core/cluster_bitmap_allocator_assert.svh */
// Assertion macros for the cluster bitmap allocator.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef CLUSTER_BITMAP_ALLOCATOR_ASSERT_SVH
`define CLUSTER_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define CBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cba_pkg.sv */
// Shared types and constants for the cluster bitmap allocator.
// No dependencies.
`timescale 1ns / 1ps

package cba_pkg;

  localparam int MAP_BYTES = 8192;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int POS_W     = (ADDR_W + 4 > 18) ? ADDR_W + 4 : 18;
  localparam logic [POS_W-1:0] MAP_BITS = POS_W'(MAP_BYTES * 8);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_TEST  = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_SEG   = 3'd4;

  localparam logic [1:0] REG_FREE_LIMIT = 2'd0;
  localparam logic [1:0] REG_DISK       = 2'd1;
  localparam logic [1:0] REG_CLUSTER    = 2'd2;
  localparam logic [1:0] REG_SEGMENT    = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] first_bit;
    logic [16:0] bit_count;
  } cba_cmd_t;

  typedef struct packed {
    logic        status;
    logic        bit_is_set;
    logic [15:0] found_bit;
    logic [31:0] segment_start;
    logic [31:0] segment_length;
  } cba_result_t;

  typedef struct packed {
    logic [16:0] free_scan_limit;
    logic [23:0] disk_sectors;
    logic [15:0] cluster_sectors;
    logic [7:0]  segment_sectors;
  } cba_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } cba_mem_req_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_RD, S_MOD, S_MUL, S_OUT
  } cba_state_t;

endpackage

/* rtl/core/cba_ram.sv */
// Single-port synchronous RAM with a registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps

module cba_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/cba_ctrl.sv */
// Sequencer that reads, modifies and writes the bitmap one byte at a time.
// Depends on cba_pkg.
`timescale 1ns / 1ps

module cba_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  cba_pkg::cba_cmd_t     cmd,
  input  cba_pkg::cba_cfg_t     cfg,
  input  logic [7:0]            mem_rdata,
  output cba_pkg::cba_mem_req_t mem_req,
  output logic                  busy,
  output logic                  done,
  output cba_pkg::cba_result_t  result
);

  localparam int PW = cba_pkg::POS_W;
  localparam int AW = cba_pkg::ADDR_W;

  cba_pkg::cba_state_t state, state_next;
  logic [AW-1:0] addr;
  logic [PW-1:0] lo, hi, seg_s;
  logic          run_val, wr_mode;
  logic [2:0]    op_r;
  logic [7:0]    runc, need, sas;
  logic [16:0]   acc;
  logic [15:0]   spc;
  cba_pkg::cba_result_t res;

  logic [PW-1:0] end_sum, hi_run, lim_free, lim_seg, st_lo, st_hi;
  logic          st_empty, op_ok;
  logic [PW-1:0] base, base_next;
  logic          last;
  logic [7:0]    mask, wbyte;
  logic          ffound, sfound;
  logic [PW-1:0] fpos, spos, pos;
  logic [7:0]    r;
  logic [PW+15:0] prod_s;

  always_comb begin
    end_sum  = PW'(cmd.first_bit) + PW'(cmd.bit_count);
    hi_run   = (end_sum > cba_pkg::MAP_BITS) ? cba_pkg::MAP_BITS : end_sum;
    lim_free = (32'(cfg.free_scan_limit) < 32'(cba_pkg::MAP_BITS)) ?
               PW'(cfg.free_scan_limit) : cba_pkg::MAP_BITS;
    lim_seg  = (32'(cfg.disk_sectors) < 32'(cba_pkg::MAP_BITS)) ?
               PW'(cfg.disk_sectors) : cba_pkg::MAP_BITS;
    op_ok    = 1'b1;
    st_lo    = PW'(cmd.first_bit);
    st_hi    = hi_run;
    case (cmd.operation)
      cba_pkg::OP_SET, cba_pkg::OP_CLEAR: begin
        st_hi = hi_run;
      end
      cba_pkg::OP_TEST: begin
        st_hi = (PW'(cmd.first_bit) < cba_pkg::MAP_BITS) ?
                PW'(cmd.first_bit) + PW'(1) : PW'(0);
      end
      cba_pkg::OP_FREE: begin
        st_lo = PW'(2);
        st_hi = lim_free;
      end
      cba_pkg::OP_SEG: begin
        st_lo = '0;
        st_hi = lim_seg;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    st_empty = st_lo >= st_hi;
  end

  always_comb begin
    base      = PW'({addr, 3'b000});
    base_next = base + PW'(8);
    last      = base_next >= hi;
    ffound    = 1'b0;
    sfound    = 1'b0;
    fpos      = '0;
    spos      = '0;
    r         = runc;
    mask      = '0;
    for (int j = 0; j < 8; j++) begin
      pos = base + PW'(j);
      mask[7-j] = (pos >= lo) && (pos < hi);
      if (mask[7-j] && !ffound && !mem_rdata[7-j]) begin
        ffound = 1'b1;
        fpos   = pos;
      end
      if (mask[7-j] && !sfound) begin
        if (mem_rdata[7-j]) begin
          r = '0;
        end else begin
          r = r + 8'd1;
          if (r == need) begin
            sfound = 1'b1;
            spos   = pos;
          end
        end
      end
    end
    wbyte  = run_val ? (mem_rdata | mask) : (mem_rdata & ~mask);
    prod_s = seg_s * spc;
  end

  always_comb begin
    state_next = state;
    case (state)
      cba_pkg::S_CLR: begin
        if (addr == cba_pkg::LAST_ADDR) state_next = cba_pkg::S_IDLE;
      end
      cba_pkg::S_IDLE: begin
        if (start) begin
          if (!op_ok) state_next = cba_pkg::S_OUT;
          else if (cmd.operation == cba_pkg::OP_SEG) state_next = cba_pkg::S_DIV;
          else if (st_empty) state_next = cba_pkg::S_OUT;
          else state_next = cba_pkg::S_RD;
        end
      end
      cba_pkg::S_DIV: begin
        if (acc >= 17'(sas)) begin
          state_next = (lo >= hi) ? cba_pkg::S_OUT : cba_pkg::S_RD;
        end
      end
      cba_pkg::S_RD: begin
        state_next = cba_pkg::S_MOD;
      end
      cba_pkg::S_MOD: begin
        if (wr_mode) begin
          if (last) begin
            state_next = (op_r == cba_pkg::OP_SEG) ? cba_pkg::S_MUL : cba_pkg::S_OUT;
          end else begin
            state_next = cba_pkg::S_RD;
          end
        end else begin
          case (op_r)
            cba_pkg::OP_FREE: begin
              state_next = (ffound || !last) ? cba_pkg::S_RD : cba_pkg::S_OUT;
            end
            cba_pkg::OP_SEG: begin
              state_next = (sfound || !last) ? cba_pkg::S_RD : cba_pkg::S_OUT;
            end
            default: begin
              state_next = cba_pkg::S_OUT;
            end
          endcase
        end
      end
      cba_pkg::S_MUL: begin
        state_next = cba_pkg::S_OUT;
      end
      cba_pkg::S_OUT: begin
        state_next = cba_pkg::S_IDLE;
      end
      default: begin
        state_next = cba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = addr;
    mem_req.wdata = wbyte;
    busy          = state != cba_pkg::S_IDLE;
    done          = state == cba_pkg::S_OUT;
    case (state)
      cba_pkg::S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = '0;
      end
      cba_pkg::S_MOD: begin
        mem_req.we = wr_mode;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cba_pkg::S_CLR;
      addr    <= '0;
      wr_mode <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        cba_pkg::S_CLR: begin
          addr <= addr + AW'(1);
        end
        cba_pkg::S_IDLE: begin
          if (start) begin
            op_r    <= cmd.operation;
            lo      <= st_lo;
            hi      <= st_hi;
            addr    <= st_lo[AW+2:3];
            run_val <= cmd.operation == cba_pkg::OP_SET;
            wr_mode <= cmd.operation inside {cba_pkg::OP_SET, cba_pkg::OP_CLEAR};
            runc    <= '0;
            acc     <= '0;
            need    <= '0;
            sas     <= (cfg.segment_sectors == 8'd0 ||
                        24'(cfg.segment_sectors) > (cfg.disk_sectors >> 1)) ?
                       8'd1 : cfg.segment_sectors;
            spc     <= (cfg.cluster_sectors == 16'd0) ? 16'd1 : cfg.cluster_sectors;
            res     <= cba_pkg::cba_result_t'({
                         cmd.operation inside {cba_pkg::OP_FREE, cba_pkg::OP_SEG},
                         81'd0});
          end
        end
        cba_pkg::S_DIV: begin
          if (acc < 17'(sas)) begin
            acc  <= acc + 17'(spc);
            need <= need + 8'd1;
          end
        end
        cba_pkg::S_MOD: begin
          if (wr_mode) begin
            addr <= addr + AW'(1);
          end else begin
            case (op_r)
              cba_pkg::OP_TEST: begin
                res.bit_is_set <= mem_rdata[3'd7 - lo[2:0]];
              end
              cba_pkg::OP_FREE: begin
                if (ffound) begin
                  res.status    <= 1'b0;
                  res.found_bit <= fpos[15:0];
                  lo            <= fpos;
                  hi            <= fpos + PW'(1);
                  run_val       <= 1'b1;
                  wr_mode       <= 1'b1;
                end else begin
                  addr <= addr + AW'(1);
                end
              end
              cba_pkg::OP_SEG: begin
                runc <= r;
                if (sfound) begin
                  res.status <= 1'b0;
                  seg_s      <= spos + PW'(1) - PW'(need);
                  lo         <= spos + PW'(1) - PW'(need);
                  hi         <= spos + PW'(1);
                  addr       <= AW'((spos + PW'(1) - PW'(need)) >> 3);
                  run_val    <= 1'b1;
                  wr_mode    <= 1'b1;
                end else begin
                  addr <= addr + AW'(1);
                end
              end
              default: begin
                addr <= addr;
              end
            endcase
          end
        end
        cba_pkg::S_MUL: begin
          res.segment_start  <= prod_s[31:0];
          res.segment_length <= 32'(need) * 32'(spc);
        end
        default: begin
          addr <= addr;
        end
      endcase
    end
  end

endmodule

/* rtl/core/cluster_bitmap_allocator.sv */
// Top level of the cluster bitmap allocator: configuration registers,
// bitmap RAM and sequencer. Depends on cba_pkg, cba_ram, cba_ctrl.
//
//   Channel   Handshake               Payload
//   command   start / busy            cmd (cba_cmd_t)
//   result    done (one-cycle pulse)  result (cba_result_t)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// After reset the bitmap RAM is swept to zero, one byte per cycle, across
// all MAP_BYTES (8192) bytes; busy stays high meanwhile.
// Each byte is read in S_RD, then modified and written back in S_MOD.
// A run update visits each byte it touches; a search scans bytes until it
// finds a free bit or run and on a hit visits each byte of the claimed bit
// or run, and a segment request first sizes the run in clusters (S_DIV)
// and at the end forms the sector products (S_MUL).
// Results are shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`include "cluster_bitmap_allocator_assert.svh"

module cluster_bitmap_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cba_pkg::cba_cmd_t    cmd,
  output logic                 done,
  output cba_pkg::cba_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  cba_pkg::cba_cfg_t     cfg;
  cba_pkg::cba_mem_req_t mem_req;
  logic [7:0]            mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_scan_limit <= 17'h10000;
      cfg.disk_sectors    <= '0;
      cfg.cluster_sectors <= 16'd1;
      cfg.segment_sectors <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cba_pkg::REG_FREE_LIMIT: cfg.free_scan_limit <= cfg_data[16:0];
        cba_pkg::REG_DISK:       cfg.disk_sectors    <= cfg_data;
        cba_pkg::REG_CLUSTER:    cfg.cluster_sectors <= cfg_data[15:0];
        cba_pkg::REG_SEGMENT:    cfg.segment_sectors <= cfg_data[7:0];
        default:                 cfg.segment_sectors <= cfg.segment_sectors;
      endcase
    end
  end

  cba_ram #(
    .DEPTH(cba_pkg::MAP_BYTES),
    .WIDTH(8)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .addr (mem_req.addr),
    .wdata(mem_req.wdata),
    .rdata(mem_rdata)
  );

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .cfg      (cfg),
    .mem_rdata(mem_rdata),
    .mem_req  (mem_req),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  `CBA_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a command")
  `CBA_ASSERT_NEXT(a_done_idle, done, !busy && !done, "no return to idle after result")
  `CBA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not start work")
  `CBA_ASSERT_NOW(a_write_busy, mem_req.we, busy, "bitmap written while idle")

endmodule
